[hdl/ial_pkg.sv]
// shared types and constants for the interval annotation lookup
// used by the cell row and the top level; no dependencies
`default_nettype none

package ial_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int POS_W       = 16;
    localparam int ID_W        = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int IN_FIELDS_W  = 2 + ID_W + 3 * POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ID_W + 1 + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ANNOT  = 2'd1,
        OP_RESET  = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    // token that walks the cell row, one cell per cycle while the row is not stalled
    typedef struct packed {
        logic             ins;
        logic             qry;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] size;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] len;
        logic             ex_hit;
        logic [ID_W-1:0]  ex_id;
        logic             ct_hit;
        logic [POS_W:0]   best;
        logic [ID_W-1:0]  ct_id;
        logic             dropped;
        logic [POS_W-1:0] cur_len;
    } wave_t;

endpackage

`default_nettype wire

[hdl/ial_cell.sv]
// one cell of the annotation row: holds one entry and updates the passing token
// depends on ial_pkg
`default_nettype none

module ial_cell
    import ial_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic [CNT_W-1:0] cell_idx,
    input  wire logic             wave_in_valid,
    input  wire wave_t            wave_in,
    output logic                  wave_out_valid,
    output wave_t                 wave_out
);

    logic [ID_W-1:0]  id_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] size_reg;
    logic             valid_reg;
    wave_t            wave_reg;
    wave_t            wave_next;

    logic             in_use;
    logic             special;
    logic             exact;
    logic [POS_W:0]   end_sum;
    logic             contains;

    always_comb begin
        in_use   = cell_idx < wave_in.cnt;
        // single entry at zero on an empty text
        special  = (cell_idx == '0) && (wave_in.len == '0) && (wave_in.pos == '0) &&
                   (wave_in.cnt == CNT_W'(1)) && (start_reg == '0);
        exact    = ((wave_in.size != '0) && (start_reg == wave_in.pos) &&
                    (size_reg == wave_in.size)) || special;
        end_sum  = {1'b0, start_reg} + {1'b0, size_reg};
        contains = (wave_in.pos >= start_reg) && ({1'b0, wave_in.pos} < end_sum) &&
                   (wave_in.best > {1'b0, size_reg});
        wave_next = wave_in;
        if (wave_in.qry && in_use) begin
            if (!wave_in.ex_hit && exact) begin
                wave_next.ex_hit = 1'b1;
                wave_next.ex_id  = id_reg;
            end
            if (contains) begin
                wave_next.ct_hit = 1'b1;
                wave_next.best   = {1'b0, size_reg};
                wave_next.ct_id  = id_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= wave_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wave_reg <= wave_next;
            if (wave_in_valid && wave_in.ins && (cell_idx == wave_in.cnt)) begin
                id_reg    <= wave_in.id;
                start_reg <= wave_in.pos;
                size_reg  <= wave_in.size;
            end
        end
    end

    assign wave_out_valid = valid_reg;
    assign wave_out       = wave_reg;

endmodule

`default_nettype wire

[hdl/interval_annotation_lookup.sv]
// top level of the interval annotation lookup: request decode, cell row, result register
// depends on ial_pkg and ial_cell
`default_nettype none

// Every request (append, annotate, reset or query) is decoded on acceptance, which
// updates the text length and entry count at once, and then launches a token down a
// row of MAX_ENTRIES cells, one cell per cycle while the row is not stalled. Each cell
// holds one table entry in order of insertion; an insert token is captured by the cell
// whose position equals the entry count, and a query token collects the exact match and
// the smallest containing entry as it passes. The result sits in an output register;
// one request is in the row at a time, so the next request is taken once the previous
// result has entered the output register. A result held by a stalled receiver stalls
// the row and holds off the next request until it drains. An insert into a full table,
// or an append that would carry the length past 16 bits, reports dropped and changes
// nothing; an empty append changes nothing. Entries need no clearing after reset.
module interval_annotation_lookup
    import ial_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // opcode, elem_id, position, span_size, segment_length, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // found, result_id, dropped, current_length, zero fill
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    // request fields
    opcode_t          in_op;
    logic [ID_W-1:0]  in_id;
    logic [POS_W-1:0] in_pos;
    logic [POS_W-1:0] in_span;
    logic [POS_W-1:0] in_seg;

    assign in_op   = opcode_t'(s_tdata[1:0]);
    assign in_id   = s_tdata[2 +: ID_W];
    assign in_pos  = s_tdata[2 + ID_W +: POS_W];
    assign in_span = s_tdata[2 + ID_W + POS_W +: POS_W];
    assign in_seg  = s_tdata[2 + ID_W + 2 * POS_W +: POS_W];

    // control state
    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] len_reg;
    logic [POS_W-1:0] len_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_FIELDS_W-1:0] out_data_reg;
    logic [OUT_FIELDS_W-1:0] out_data_next;

    logic             accept;
    logic             adv;
    logic [POS_W:0]   sum_len;
    logic             full;
    wave_t            launch;

    // cell row
    wave_t wave  [0:MAX_ENTRIES];
    logic  wvalid[0:MAX_ENTRIES];

    assign accept = s_tvalid && s_tready;
    // a new request enters cell 0 only when the row moves
    assign s_tready = !busy_reg && adv;
    // the row stalls only when the result register is full and not drained
    assign adv = !out_valid_reg || m_tready;

    assign sum_len = {1'b0, len_reg} + {1'b0, in_seg};
    assign full    = count_reg == CNT_W'(MAX_ENTRIES);

    // decode the request and update length and count on acceptance
    always_comb begin
        count_next = count_reg;
        len_next   = len_reg;
        launch         = '0;
        launch.id      = in_id;
        launch.cnt     = count_reg;
        launch.len     = len_reg;
        launch.best    = {1'b0, len_reg} + (POS_W + 1)'(1);
        unique case (in_op)
            OP_APPEND: begin
                launch.pos  = len_reg;
                launch.size = in_seg;
                if (in_seg != '0) begin
                    if (sum_len[POS_W] || full) begin
                        launch.dropped = 1'b1;
                    end else begin
                        launch.ins = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        len_next   = sum_len[POS_W-1:0];
                    end
                end
            end
            OP_ANNOT: begin
                launch.pos  = in_pos;
                launch.size = in_span;
                if (full) begin
                    launch.dropped = 1'b1;
                end else begin
                    launch.ins = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_RESET: begin
                count_next = '0;
                len_next   = '0;
            end
            OP_QUERY: begin
                launch.qry  = 1'b1;
                launch.pos  = in_pos;
                launch.size = in_span;
            end
            default: begin
            end
        endcase
        launch.cur_len = len_next;
    end

    assign wave[0]   = launch;
    assign wvalid[0] = accept;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        ial_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .adv            (adv),
            .cell_idx       (CNT_W'(g)),
            .wave_in_valid  (wvalid[g]),
            .wave_in        (wave[g]),
            .wave_out_valid (wvalid[g+1]),
            .wave_out       (wave[g+1])
        );
    end

    // result capture at the end of the row
    always_comb begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
        if (adv && wvalid[MAX_ENTRIES]) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = {wave[MAX_ENTRIES].cur_len,
                              wave[MAX_ENTRIES].dropped,
                              wave[MAX_ENTRIES].ex_hit ? wave[MAX_ENTRIES].ex_id
                                                       : (wave[MAX_ENTRIES].ct_hit ?
                                                          wave[MAX_ENTRIES].ct_id : '0),
                              wave[MAX_ENTRIES].ex_hit | wave[MAX_ENTRIES].ct_hit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (accept) begin
                count_reg <= count_next;
                len_reg   <= len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[hdl/ial_checker.sv]
// port-level checks for the interval annotation lookup, bound to the top level
// depends on ial_pkg and interval_annotation_lookup
`default_nettype none

module ial_checker
    import ial_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("request changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a miss reports id zero
    a_miss_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[ID_W:1] == '0)
        else $error("nonzero id on miss");

    // a result is never both a hit and a drop
    a_hit_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[ID_W+1]))
        else $error("found and dropped together");

endmodule

bind interval_annotation_lookup ial_checker u_ial_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/ial_checker.sv]
// reply checker for the interval annotation lookup: watches both stream channels,
// keeps its own copy of the annotation table and text length, and compares every reply
// depends on ial_pkg for widths, table depth and opcode names

module ial_reply_checker
    import ial_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    output int                          mismatches,
    output int                          outstanding
);

    localparam int unsigned POS_TOP = (1 << POS_W) - 1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] size;
    } span_entry_t;

    // members listed msb first, so found sits in bit 0 as on the bus
    typedef struct packed {
        logic [POS_W-1:0] current_length;
        logic             dropped;
        logic [ID_W-1:0]  result_id;
        logic             found;
    } reply_t;

    span_entry_t      span_table [MAX_ENTRIES];
    int unsigned      span_count;
    logic [POS_W-1:0] text_len;
    reply_t           awaited_replies [$];

    // applies one request to the private table and returns the reply it should produce
    function automatic reply_t lookup_outcome(input logic [IN_TDATA_W-1:0] word);
        opcode_t          op;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] seg;
        reply_t           r;
        int unsigned      best;
        int unsigned      lo;
        int unsigned      hi;
        logic             matched;
        op   = opcode_t'(word[1:0]);
        id   = word[2 +: ID_W];
        pos  = word[2 + ID_W +: POS_W];
        span = word[2 + ID_W + POS_W +: POS_W];
        seg  = word[2 + ID_W + 2 * POS_W +: POS_W];
        r    = '0;
        case (op)
            OP_APPEND: begin
                if (seg != 0) begin
                    if (int'(text_len) + int'(seg) > POS_TOP || span_count >= MAX_ENTRIES) begin
                        r.dropped = 1'b1;
                    end else begin
                        span_table[span_count] = '{id: id, start: text_len, size: seg};
                        span_count++;
                        text_len = text_len + seg;
                    end
                end
            end
            OP_ANNOT: begin
                if (span_count >= MAX_ENTRIES) begin
                    r.dropped = 1'b1;
                end else begin
                    span_table[span_count] = '{id: id, start: pos, size: span};
                    span_count++;
                end
            end
            OP_RESET: begin
                span_count = 0;
                text_len   = '0;
            end
            default: begin
                matched = 1'b0;
                // empty text with a single entry at zero answers position zero
                if (text_len == 0 && pos == 0 && span_count == 1 && span_table[0].start == 0) begin
                    matched     = 1'b1;
                    r.result_id = span_table[0].id;
                end
                if (!matched && span != 0) begin
                    for (int i = 0; i < span_count; i++) begin
                        if (!matched && span_table[i].start == pos && span_table[i].size == span) begin
                            matched     = 1'b1;
                            r.result_id = span_table[i].id;
                        end
                    end
                end
                // first of the smallest containing entries, size capped by the length
                if (!matched) begin
                    best = int'(text_len) + 1;
                    for (int i = 0; i < span_count; i++) begin
                        lo = span_table[i].start;
                        hi = lo + span_table[i].size;
                        if (pos >= lo && pos < hi && span_table[i].size < best) begin
                            best        = span_table[i].size;
                            matched     = 1'b1;
                            r.result_id = span_table[i].id;
                        end
                    end
                end
                r.found = matched;
            end
        endcase
        r.current_length = text_len;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t seen;
        reply_t want;
        if (!aresetn) begin
            span_count = 0;
            text_len   = '0;
            awaited_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = reply_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual %h", $time, seen);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("found", want.found, seen.found);
                    compare_field("result_id", want.result_id, seen.result_id);
                    compare_field("dropped", want.dropped, seen.dropped);
                    compare_field("current_length", want.current_length, seen.current_length);
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(lookup_outcome(s_tdata));
        end
        outstanding <= awaited_replies.size();
    end

endmodule

[tb/tb_top.sv]
// top of the interval annotation lookup bench: clock, reset, request stimulus and verdict
// depends on ial_pkg, interval_annotation_lookup and ial_reply_checker

module tb_top;
    import ial_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1950;
    // drain wait: room for two requests through the row, plus margin
    localparam int DRAIN_CYCLES = 2 * (MAX_ENTRIES + 1) + 20;
    localparam int unsigned POS_TOP = (1 << POS_W) - 1;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // opcode, elem_id, position, span_size, segment_length, zero fill
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // found, result_id, dropped, current_length, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     mismatches;
    int                     outstanding;

    // no idling on either side while set
    logic        calm = 1'b0;
    int unsigned sent;
    int unsigned next_fill;

    // rough view of the table, only used to aim queries and inserts
    int unsigned aim_count;
    int unsigned aim_length;
    int unsigned aim_start [MAX_ENTRIES];
    int unsigned aim_size  [MAX_ENTRIES];

    always #6 aclk = ~aclk;

    interval_annotation_lookup DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ial_reply_checker reply_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver stalls at random, about 21 percent of the time, except during the calm stretch
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // one request: optional random gap, then hold valid until the handshake
    task automatic send_request(input opcode_t op, input int unsigned id, pos, span, seg);
        logic [IN_TDATA_W-1:0] word;
        pos  &= POS_TOP;
        span &= POS_TOP;
        seg  &= POS_TOP;
        word = '0;
        word[1:0]                          = op;
        word[2 +: ID_W]                    = id[ID_W-1:0];
        word[2 + ID_W +: POS_W]            = pos[POS_W-1:0];
        word[2 + ID_W + POS_W +: POS_W]    = span[POS_W-1:0];
        word[2 + ID_W + 2 * POS_W +: POS_W] = seg[POS_W-1:0];
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        // keep the aiming view in step with what the block will store
        case (op)
            OP_APPEND: begin
                if (seg != 0 && aim_length + seg <= POS_TOP && aim_count < MAX_ENTRIES) begin
                    aim_start[aim_count] = aim_length;
                    aim_size[aim_count]  = seg;
                    aim_count++;
                    aim_length += seg;
                end
            end
            OP_ANNOT: begin
                if (aim_count < MAX_ENTRIES) begin
                    aim_start[aim_count] = pos;
                    aim_size[aim_count]  = span;
                    aim_count++;
                end
            end
            OP_RESET: begin
                aim_count  = 0;
                aim_length = 0;
            end
            default: ;
        endcase
        // an empty append is ignored by the block and does not count
        if (!(op == OP_APPEND && seg == 0))
            sent++;
    endtask

    // query aimed mostly at stored entries: their starts, insides, ends and exact sizes
    task automatic query_request();
        int unsigned k;
        int unsigned pos;
        int unsigned span;
        k = (aim_count > 0) ? $urandom_range(aim_count - 1) : 0;
        case ($urandom_range(9))
            0:       pos = 0;
            1:       pos = $urandom_range(POS_TOP);
            2, 3:    pos = aim_start[k];
            default: pos = aim_start[k] + $urandom_range(aim_size[k]);
        endcase
        case ($urandom_range(4))
            0, 1:    span = 0;
            2, 3:    span = aim_size[k];
            default: span = $urandom_range(POS_TOP);
        endcase
        send_request(OP_QUERY, $urandom, pos, span, $urandom);
    endtask

    task automatic append_request();
        int unsigned seg;
        case ($urandom_range(19))
            0:       seg = 0;
            1:       seg = $urandom_range(POS_TOP);
            2:       seg = POS_TOP - aim_length;   // lands exactly on the top length
            3:       seg = $urandom_range(16'h8000, POS_TOP);
            default: seg = $urandom_range(1, 200);
        endcase
        send_request(OP_APPEND, $urandom, $urandom, $urandom, seg);
    endtask

    task automatic annotate_request();
        int unsigned pos;
        int unsigned span;
        case ($urandom_range(3))
            0:       pos = 0;
            1:       pos = $urandom_range(POS_TOP);
            default: pos = $urandom_range(aim_length);
        endcase
        case ($urandom_range(3))
            0:       span = 0;
            1:       span = $urandom_range(POS_TOP);
            default: span = $urandom_range(1, 40);
        endcase
        send_request(OP_ANNOT, $urandom, pos, span, $urandom);
    endtask

    task automatic random_request();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            append_request();
        else if (roll < 45)
            annotate_request();
        else if (roll < 48)
            send_request(OP_RESET, $urandom, $urandom, $urandom, $urandom);
        else
            query_request();
    endtask

    // clear, fill the table to capacity with queries mixed in, then push past full
    task automatic fill_table();
        send_request(OP_RESET, $urandom, $urandom, $urandom, $urandom);
        while (aim_count < MAX_ENTRIES) begin
            if ($urandom_range(3) == 0)
                query_request();
            else if ($urandom_range(1) == 0)
                send_request(OP_APPEND, $urandom, $urandom, $urandom, $urandom_range(1, 50));
            else
                annotate_request();
        end
        repeat (12) begin
            if ($urandom_range(1) == 0)
                query_request();
            else if ($urandom_range(1) == 0)
                send_request(OP_APPEND, $urandom, $urandom, $urandom, $urandom_range(1, 50));
            else
                annotate_request();
        end
    endtask

    // run limit, several times the slowest correct run
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[interval_annotation_lookup] ERROR");
        $finish;
    end

    initial begin : stimulus
        sent       = 0;
        next_fill  = 300;
        aim_count  = 0;
        aim_length = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        // query on an empty table, then an empty append
        send_request(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_APPEND, 16'h1111, 16'h0000, 16'h0000, 16'h0000);
        // zero-size entry at zero with empty text answers position zero
        send_request(OP_ANNOT,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'h0000, 16'h0005, 16'h0000);
        // single character segment, then a containing match
        send_request(OP_APPEND, 16'h1234, 16'h0000, 16'h0000, 16'h0001);
        send_request(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // entry at the top of the range, its end passes the top without wrap
        send_request(OP_ANNOT,  16'hA5A5, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        // length overflow, then an append that fills the length exactly
        send_request(OP_APPEND, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(OP_APPEND, 16'h0002, 16'h0000, 16'h0000, 16'hFFFE);
        send_request(OP_QUERY,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'h0064, 16'h0000, 16'h0000);
        send_request(OP_APPEND, 16'h0003, 16'h0000, 16'h0000, 16'h0001);
        // clear, then ties between equal entries
        send_request(OP_RESET,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_ANNOT,  16'h0007, 16'h0003, 16'h0002, 16'h0000);
        send_request(OP_ANNOT,  16'h0008, 16'h0003, 16'h0002, 16'h0000);
        send_request(OP_QUERY,  16'h0000, 16'h0003, 16'h0002, 16'h0000);
        send_request(OP_APPEND, 16'h0009, 16'h0000, 16'h0000, 16'h000A);
        send_request(OP_QUERY,  16'h0000, 16'h0004, 16'h0000, 16'h0000);
        // wanted size with no exact entry falls back to containment
        send_request(OP_QUERY,  16'h0000, 16'h0004, 16'h0007, 16'h0000);
        send_request(OP_RESET,  16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random part with a few full-table episodes and one calm stretch
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 800 && sent < 1100);
            if (sent >= next_fill) begin
                fill_table();
                next_fill += 600;
            end else begin
                random_request();
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // wait for every awaited reply, then for the block to settle
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("[interval_annotation_lookup] OK");
        else
            $display("[interval_annotation_lookup] ERROR");
        $finish;
    end

endmodule
